>>> rtl/hs_pkg.sv
// ---------------------------------------------------------------------------
// hs_pkg
// Shared constants, word types and sequencer states of the heap sort core.
// ---------------------------------------------------------------------------
package hs_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int KEY_W  = 32;

	typedef logic [ADDR_W-1:0]       addr_t;
	typedef logic [ADDR_W+1:0]       child_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic                    final_key;
	} in_word_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] sorted_key;
		logic                    run_end;
		logic                    dropped;
	} out_word_t;

	// one write port and two read ports per cycle
	typedef struct packed {
		logic              we;
		addr_t             waddr;
		logic [KEY_W-1:0]  wdata;
		addr_t             raddr_a;
		addr_t             raddr_b;
	} ram_req_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_FETCH,
		ST_SIFT_RD,
		ST_SIFT_CMP,
		ST_X_RD,
		ST_X_WR,
		ST_EMIT_RD,
		ST_EMIT_CAP,
		ST_EMIT_HOLD
	} state_t;

endpackage

>>> rtl/hs_in_if.sv
// ---------------------------------------------------------------------------
// hs_in_if
// Valid/ready channel carrying one unsorted key word.
// ---------------------------------------------------------------------------
interface hs_in_if import hs_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/hs_out_if.sv
// ---------------------------------------------------------------------------
// hs_out_if
// Valid/ready channel carrying one sorted key word.
// ---------------------------------------------------------------------------
interface hs_out_if import hs_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/heap_sort_core.sv
// ---------------------------------------------------------------------------
// heap_sort_core
// In-place heapsort of a run of signed Q16.16 keys, emitted in ascending order.
// ---------------------------------------------------------------------------
// Usage:
//   Send keys on 'unsorted', one word per key; set final_key on the last one.
//   Up to DEPTH keys are held; further keys of the run are discarded and every
//   result word of that run carries dropped = 1.
//   After the final key the core heapifies and sorts the key memory in place,
//   then sends every held key on 'sorted', smallest first, run_end on the last.
// Timing:
//   Loading takes one cycle per key. Each sift level reads both children,
//   then compares and writes back into the hole. Emission reads each word
//   from the key memory and offers it; the read of the next word is issued
//   only once the current word has been taken.
//   The shared key memory (one write, two reads per cycle) limits the pace.
// Reset and flow control:
//   arst_n clears the key count, the overflow flag and the output valid; the
//   memory contents are not cleared, since only written entries are read.
//   'unsorted' is ready only while loading. A stalled receiver holds the
//   current result word and freezes the sequencer until it is taken.
// ---------------------------------------------------------------------------
module heap_sort_core import hs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	hs_in_if.sink    unsorted,
	hs_out_if.source sorted
);

	ram_req_t         ram_req;
	logic [KEY_W-1:0] rd_a;
	logic [KEY_W-1:0] rd_b;

	// sequencer: load, build heap, extract maxima, emit words
	hs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.unsorted (unsorted),
		.sorted   (sorted),
		.ram_req  (ram_req),
		.rd_a     (rd_a),
		.rd_b     (rd_b)
	);

	// key memory: writes land at the edge, read data is registered
	hs_ram #(
		.DATA_W (KEY_W),
		.WORDS  (DEPTH),
		.AW     (ADDR_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_req.we),
		.waddr   (ram_req.waddr),
		.wdata   (ram_req.wdata),
		.raddr_a (ram_req.raddr_a),
		.raddr_b (ram_req.raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

endmodule

>>> rtl/hs_ram.sv
// ---------------------------------------------------------------------------
// hs_ram
// Generic RAM, one write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
module hs_ram #(
	parameter int DATA_W = 32,
	parameter int WORDS  = 64,
	parameter int AW     = $clog2(WORDS)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr_a,
	input  logic [AW-1:0]     raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> rtl/hs_seq.sv
// ---------------------------------------------------------------------------
// hs_seq
// Load, heapify, extract and emit sequencer of the heap sort core.
// ---------------------------------------------------------------------------
module hs_seq import hs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	hs_in_if.sink            unsorted,
	hs_out_if.source         sorted,
	output ram_req_t         ram_req,
	input  logic [KEY_W-1:0] rd_a,
	input  logic [KEY_W-1:0] rd_b
);

	state_t    state_q, state_d;
	cnt_t      cnt_q, cnt_d;
	logic      ovf_q, ovf_d;
	logic      build_q, build_d;
	logic      take_v_q, take_v_d;
	logic      out_valid_q, out_valid_d;
	addr_t     i_q, i_d;
	addr_t     node_q, node_d;
	addr_t     last_q, last_d;
	addr_t     k_q, k_d;
	key_t      v_q, v_d;
	out_word_t out_q, out_d;

	key_t      v_cur;
	key_t      l_key, r_key, best;
	child_t    left, right;
	logic      left_ok, right_ok;
	logic      sift_end;
	cnt_t      cnt_n;
	logic      full;

	assign unsorted.ready = (state_q == ST_LOAD);
	assign sorted.valid   = out_valid_q;
	assign sorted.data    = out_q;

	assign left     = {1'b0, node_q, 1'b1};
	assign right    = child_t'({1'b0, node_q, 1'b0}) + child_t'(2);
	assign left_ok  = left <= child_t'(last_q);
	assign right_ok = right <= child_t'(last_q);
	assign v_cur    = take_v_q ? $signed(rd_a) : v_q;
	assign l_key    = $signed(rd_a);
	assign r_key    = $signed(rd_b);
	assign full     = (cnt_q == cnt_t'(DEPTH));

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		ovf_d       = ovf_q;
		build_d     = build_q;
		take_v_d    = take_v_q;
		out_valid_d = out_valid_q;
		i_d         = i_q;
		node_d      = node_q;
		last_d      = last_q;
		k_d         = k_q;
		v_d         = v_q;
		out_d       = out_q;
		ram_req     = '0;
		sift_end    = 1'b0;
		cnt_n       = cnt_q;
		best        = v_cur;

		unique case (state_q)
			ST_LOAD: begin
				if (unsorted.valid) begin
					if (!full) begin
						ram_req.we    = 1'b1;
						ram_req.waddr = cnt_q[ADDR_W-1:0];
						ram_req.wdata = unsorted.data.key;
						cnt_n         = cnt_q + cnt_t'(1);
					end else begin
						ovf_d = 1'b1;
					end
					cnt_d = cnt_n;
					if (unsorted.data.final_key) begin
						if (cnt_n < cnt_t'(2)) begin
							k_d     = '0;
							state_d = ST_EMIT_RD;
						end else begin
							build_d = 1'b1;
							last_d  = addr_t'(cnt_n - cnt_t'(1));
							i_d     = addr_t'((cnt_n >> 1) - cnt_t'(1));
							node_d  = addr_t'((cnt_n >> 1) - cnt_t'(1));
							state_d = ST_FETCH;
						end
					end
				end
			end
			ST_FETCH: begin
				ram_req.raddr_a = node_q;
				take_v_d        = 1'b1;
				state_d         = ST_SIFT_RD;
			end
			ST_SIFT_RD: begin
				v_d      = v_cur;
				take_v_d = 1'b0;
				if (!left_ok) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = node_q;
					ram_req.wdata = v_cur;
					sift_end      = 1'b1;
				end else begin
					ram_req.raddr_a = left[ADDR_W-1:0];
					ram_req.raddr_b = right_ok ? right[ADDR_W-1:0] : left[ADDR_W-1:0];
					state_d         = ST_SIFT_CMP;
				end
			end
			ST_SIFT_CMP: begin
				// larger child moves up into the hole if it exceeds the hole key, ties keep the left child
				ram_req.we    = 1'b1;
				ram_req.waddr = node_q;
				if (l_key > v_q) begin
					best   = l_key;
					node_d = left[ADDR_W-1:0];
				end else begin
					best = v_q;
				end
				if (right_ok && (r_key > best)) begin
					best   = r_key;
					node_d = right[ADDR_W-1:0];
				end
				ram_req.wdata = best;
				if (node_d == node_q) begin
					sift_end = 1'b1;
				end else begin
					state_d = ST_SIFT_RD;
				end
			end
			ST_X_RD: begin
				ram_req.raddr_a = '0;
				ram_req.raddr_b = i_q;
				state_d         = ST_X_WR;
			end
			ST_X_WR: begin
				// root goes to the tail, tail value becomes the hole key
				ram_req.we    = 1'b1;
				ram_req.waddr = i_q;
				ram_req.wdata = rd_a;
				v_d           = r_key;
				take_v_d      = 1'b0;
				node_d        = '0;
				last_d        = i_q - addr_t'(1);
				state_d       = ST_SIFT_RD;
			end
			ST_EMIT_RD: begin
				ram_req.raddr_a = k_q;
				state_d         = ST_EMIT_CAP;
			end
			ST_EMIT_CAP: begin
				out_valid_d      = 1'b1;
				out_d.sorted_key = l_key;
				out_d.run_end    = (cnt_t'(k_q) == cnt_q - cnt_t'(1));
				out_d.dropped    = ovf_q;
				state_d          = ST_EMIT_HOLD;
			end
			ST_EMIT_HOLD: begin
				if (sorted.ready) begin
					out_valid_d = 1'b0;
					if (out_q.run_end) begin
						cnt_d   = '0;
						ovf_d   = 1'b0;
						state_d = ST_LOAD;
					end else begin
						ram_req.raddr_a = k_q + addr_t'(1);
						k_d             = k_q + addr_t'(1);
						state_d         = ST_EMIT_CAP;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase

		if (sift_end) begin
			if (build_q) begin
				if (i_q == '0) begin
					build_d = 1'b0;
					i_d     = last_q;
					state_d = ST_X_RD;
				end else begin
					i_d     = i_q - addr_t'(1);
					node_d  = i_q - addr_t'(1);
					state_d = ST_FETCH;
				end
			end else begin
				if (i_q == addr_t'(1)) begin
					k_d     = '0;
					state_d = ST_EMIT_RD;
				end else begin
					i_d     = i_q - addr_t'(1);
					state_d = ST_X_RD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			build_q     <= 1'b0;
			take_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			ovf_q       <= ovf_d;
			build_q     <= build_d;
			take_v_q    <= take_v_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q    <= i_d;
		node_q <= node_d;
		last_q <= last_d;
		k_q    <= k_d;
		v_q    <= v_d;
		out_q  <= out_d;
	end

endmodule

>>> rtl/hs_check.sv
// ---------------------------------------------------------------------------
// hs_check
// Port-level checks of the heap sort core, bound to the top level.
// ---------------------------------------------------------------------------
module hs_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_final,
	input logic out_valid,
	input logic out_ready,
	input logic out_run_end
);

	// a waiting result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word withdrawn while stalled");

	// no loading while results are offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready during emission");

	// the final key closes the input side
	a_final_stops: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_final |=> !in_ready)
		else $error("input still ready after final key");

	// nothing follows the end of a run
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_run_end |=> !out_valid)
		else $error("result word after run end");

endmodule

bind heap_sort_core hs_check u_hs_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (unsorted.valid),
	.in_ready    (unsorted.ready),
	.in_final    (unsorted.data.final_key),
	.out_valid   (sorted.valid),
	.out_ready   (sorted.ready),
	.out_run_end (sorted.data.run_end)
);
